// ----- hdl/first_fit_segment_allocator_assert.svh -----
// Assertion macros for the checker of the segment allocator.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFSA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

// ----- hdl/ffsa_pkg.sv -----
package ffsa_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_code_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_ACCEPT,
		OP_RD_I,
		OP_TEST,
		OP_SETJ,
		OP_RD_JM1,
		OP_W_JM,
		OP_SPLIT,
		OP_CLAIM,
		OP_MARK,
		OP_TEST_R,
		OP_RD_JP1,
		OP_W_JP,
		OP_DEC,
		OP_RD_L,
		OP_TEST_L,
		OP_W_L,
		OP_W_E,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t       op;
		status_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic size_zero;
		logic req_free;
		logic hit;
		logic last_i;
		logic exact;
		logic full;
		logic at_zero;
		logic r_free;
		logic up_done;
		logic dn_done;
		logic out_free;
	} dp_flags_t;

	localparam logic [15:0] HEAP_RESET = 16'd1024;

endpackage

// ----- hdl/ffsa_ram.sv -----
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/ffsa_ctrl.sv -----
module ffsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                heap_size_we,
	input  logic                s_tvalid,
	input  ffsa_pkg::dp_flags_t flags,
	output ffsa_pkg::dp_cmd_t   cmd,
	output logic                ready
);

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_TEST,
		S_AFOUND,
		S_SHUP,
		S_SHUP_WR,
		S_SPLIT,
		S_CLAIM,
		S_FMARK,
		S_TEST_R,
		S_SHDN,
		S_SHDN_WR,
		S_LEFT,
		S_TEST_L,
		S_W_L,
		S_W_E,
		S_RESULT
	} state_t;

	state_t                 state_q, state_d;
	ffsa_pkg::status_code_t code_q, code_d;
	logic                   left_q, left_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		left_d  = left_q;
		cmd.op  = ffsa_pkg::OP_NONE;
		cmd.code = code_q;
		case (state_q)
			S_INIT: begin
				cmd.op  = ffsa_pkg::OP_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (heap_size_we) begin
					state_d = S_INIT;
				end else if (s_tvalid) begin
					cmd.op  = ffsa_pkg::OP_ACCEPT;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (!flags.req_free && flags.size_zero) begin
					code_d  = ffsa_pkg::ST_NO_SPACE;
					state_d = S_RESULT;
				end else begin
					cmd.op  = ffsa_pkg::OP_RD_I;
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				cmd.op = ffsa_pkg::OP_TEST;
				if (flags.hit) begin
					state_d = flags.req_free ? S_FMARK : S_AFOUND;
				end else if (flags.last_i) begin
					code_d  = flags.req_free ? ffsa_pkg::ST_NOT_FOUND : ffsa_pkg::ST_NO_SPACE;
					state_d = S_RESULT;
				end else begin
					state_d = S_RD;
				end
			end
			S_AFOUND: begin
				if (flags.exact) begin
					state_d = S_CLAIM;
				end else if (flags.full) begin
					code_d  = ffsa_pkg::ST_FULL;
					state_d = S_RESULT;
				end else begin
					cmd.op  = ffsa_pkg::OP_SETJ;
					state_d = S_SHUP;
				end
			end
			S_SHUP: begin
				if (flags.up_done) begin
					state_d = S_SPLIT;
				end else begin
					cmd.op  = ffsa_pkg::OP_RD_JM1;
					state_d = S_SHUP_WR;
				end
			end
			S_SHUP_WR: begin
				cmd.op  = ffsa_pkg::OP_W_JM;
				state_d = S_SHUP;
			end
			S_SPLIT: begin
				cmd.op  = ffsa_pkg::OP_SPLIT;
				state_d = S_CLAIM;
			end
			S_CLAIM: begin
				cmd.op  = ffsa_pkg::OP_CLAIM;
				code_d  = ffsa_pkg::ST_OK;
				state_d = S_RESULT;
			end
			S_FMARK: begin
				// Marking also starts the read of the right neighbor.
				cmd.op  = ffsa_pkg::OP_MARK;
				left_d  = 1'b0;
				state_d = flags.last_i ? S_LEFT : S_TEST_R;
			end
			S_TEST_R: begin
				cmd.op  = ffsa_pkg::OP_TEST_R;
				state_d = flags.r_free ? S_SHDN : S_LEFT;
			end
			S_SHDN: begin
				if (flags.dn_done) begin
					cmd.op = ffsa_pkg::OP_DEC;
					if (left_q) begin
						code_d  = ffsa_pkg::ST_OK;
						state_d = S_RESULT;
					end else begin
						state_d = S_LEFT;
					end
				end else begin
					cmd.op  = ffsa_pkg::OP_RD_JP1;
					state_d = S_SHDN_WR;
				end
			end
			S_SHDN_WR: begin
				cmd.op  = ffsa_pkg::OP_W_JP;
				state_d = S_SHDN;
			end
			S_LEFT: begin
				if (flags.at_zero) begin
					state_d = S_W_E;
				end else begin
					cmd.op  = ffsa_pkg::OP_RD_L;
					state_d = S_TEST_L;
				end
			end
			S_TEST_L: begin
				cmd.op  = ffsa_pkg::OP_TEST_L;
				state_d = flags.r_free ? S_W_L : S_W_E;
			end
			S_W_L: begin
				cmd.op  = ffsa_pkg::OP_W_L;
				left_d  = 1'b1;
				state_d = S_SHDN;
			end
			S_W_E: begin
				cmd.op  = ffsa_pkg::OP_W_E;
				code_d  = ffsa_pkg::ST_OK;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (flags.out_free) begin
					cmd.op  = ffsa_pkg::OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			code_q  <= ffsa_pkg::ST_OK;
			left_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			left_q  <= left_d;
		end
	end

	// A heap size write takes priority over a request in the same cycle.
	assign ready = (state_q == S_IDLE) && !heap_size_we;

endmodule

// ----- hdl/ffsa_dp.sv -----
module ffsa_dp #(
	parameter int MAX_SEGMENTS = 64,
	parameter int OWNER_BITS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffsa_pkg::dp_cmd_t   cmd,
	output ffsa_pkg::dp_flags_t flags,
	input  logic                heap_size_we,
	input  logic [15:0]         heap_size,
	input  logic                req_type,
	input  logic [7:0]          owner_id,
	input  logic [15:0]         alloc_size,
	input  logic [15:0]         free_start,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [1:0]          status,
	output logic [15:0]         result_start
);

	localparam int IDX_W    = $clog2(MAX_SEGMENTS);
	localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
	localparam int ENT_W    = OWNER_BITS + 33;
	localparam int OWN_LO   = 1;
	localparam int LEN_LO   = OWNER_BITS + 1;
	localparam int START_LO = OWNER_BITS + 17;

	// Entry layout from bit 0 up: free mark, owner, length, start.
	function automatic logic [ENT_W-1:0] pack_ent(input logic [15:0] st, input logic [15:0] ln,
			input logic [OWNER_BITS-1:0] ow, input logic fr);
		return {st, ln, ow, fr};
	endfunction

	logic [15:0]            heap_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       i_q, j_q;
	logic                   req_q;
	logic [OWNER_BITS-1:0]  own_q;
	logic [15:0]            size_q, fst_q;
	logic [ENT_W-1:0]       ent_q, nb_q;
	logic                   m_tvalid_q;
	logic [1:0]             status_q;
	logic [15:0]            start_q;

	logic                   we;
	logic [IDX_W-1:0]       waddr, raddr;
	logic [ENT_W-1:0]       wdata, rd_ent;
	logic [OWNER_BITS+7:0]  own_ext;

	wire [15:0]            ent_start = ent_q[START_LO +: 16];
	wire [15:0]            ent_len   = ent_q[LEN_LO +: 16];
	wire [15:0]            rd_start  = rd_ent[START_LO +: 16];
	wire [15:0]            rd_len    = rd_ent[LEN_LO +: 16];
	wire [OWNER_BITS-1:0]  rd_own    = rd_ent[OWN_LO +: OWNER_BITS];
	wire                   rd_free   = rd_ent[0];

	assign own_ext = {{OWNER_BITS{1'b0}}, owner_id};

	ffsa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SEGMENTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_ent)
	);

	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = rd_ent;
		raddr = i_q;
		case (cmd.op)
			ffsa_pkg::OP_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = pack_ent(16'd0, heap_q, '0, 1'b1);
			end
			ffsa_pkg::OP_RD_JM1: raddr = j_q - IDX_W'(1);
			ffsa_pkg::OP_W_JM: begin
				we    = 1'b1;
				waddr = j_q;
			end
			ffsa_pkg::OP_SPLIT: begin
				we    = 1'b1;
				waddr = i_q + IDX_W'(1);
				wdata = pack_ent(ent_start + size_q, ent_len - size_q, '0, 1'b1);
			end
			ffsa_pkg::OP_CLAIM: begin
				we    = 1'b1;
				wdata = pack_ent(ent_start, size_q, own_q, 1'b0);
			end
			ffsa_pkg::OP_MARK:   raddr = i_q + IDX_W'(1);
			ffsa_pkg::OP_RD_JP1: raddr = j_q + IDX_W'(1);
			ffsa_pkg::OP_W_JP: begin
				we    = 1'b1;
				waddr = j_q;
			end
			ffsa_pkg::OP_RD_L: raddr = i_q - IDX_W'(1);
			ffsa_pkg::OP_W_L: begin
				we    = 1'b1;
				waddr = i_q - IDX_W'(1);
				wdata = nb_q;
			end
			ffsa_pkg::OP_W_E: begin
				we    = 1'b1;
				wdata = ent_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		flags.size_zero = (size_q == 16'd0);
		flags.req_free  = req_q;
		flags.hit       = req_q ? (!rd_free && rd_own == own_q && rd_start == fst_q)
		                        : (rd_free && rd_len >= size_q);
		flags.last_i    = (CNT_W'(i_q) + CNT_W'(1) == count_q);
		flags.exact     = (ent_len == size_q);
		flags.full      = (count_q == CNT_W'(MAX_SEGMENTS));
		flags.at_zero   = (i_q == '0);
		flags.r_free    = rd_free;
		flags.up_done   = (CNT_W'(j_q) == CNT_W'(i_q) + CNT_W'(1));
		flags.dn_done   = (CNT_W'(j_q) + CNT_W'(1) == count_q);
		flags.out_free  = !m_tvalid_q || m_tready;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q     <= ffsa_pkg::HEAP_RESET;
			count_q    <= CNT_W'(1);
			i_q        <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (heap_size_we) begin
				heap_q <= heap_size;
			end
			case (cmd.op)
				ffsa_pkg::OP_INIT:   count_q <= CNT_W'(1);
				ffsa_pkg::OP_ACCEPT: i_q <= '0;
				ffsa_pkg::OP_TEST: begin
					if (!flags.hit) begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				ffsa_pkg::OP_SETJ:  j_q <= count_q[IDX_W-1:0];
				ffsa_pkg::OP_W_JM:  j_q <= j_q - IDX_W'(1);
				ffsa_pkg::OP_SPLIT: count_q <= count_q + CNT_W'(1);
				ffsa_pkg::OP_TEST_R: begin
					if (rd_free) begin
						j_q <= i_q + IDX_W'(1);
					end
				end
				ffsa_pkg::OP_W_JP: j_q <= j_q + IDX_W'(1);
				ffsa_pkg::OP_DEC:  count_q <= count_q - CNT_W'(1);
				ffsa_pkg::OP_W_L:  j_q <= i_q;
				default: ;
			endcase
			if (cmd.op == ffsa_pkg::OP_RESULT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			ffsa_pkg::OP_ACCEPT: begin
				req_q  <= req_type;
				own_q  <= own_ext[OWNER_BITS-1:0];
				size_q <= alloc_size;
				fst_q  <= free_start;
			end
			ffsa_pkg::OP_TEST: ent_q <= rd_ent;
			ffsa_pkg::OP_MARK: ent_q <= pack_ent(ent_start, ent_len, '0, 1'b1);
			ffsa_pkg::OP_TEST_R: begin
				if (rd_free) begin
					ent_q[LEN_LO +: 16] <= ent_len + rd_len;
				end
			end
			ffsa_pkg::OP_TEST_L: nb_q <= pack_ent(rd_start, rd_len + ent_len, rd_own, rd_free);
			ffsa_pkg::OP_RESULT: begin
				status_q <= cmd.code;
				start_q  <= (cmd.code == ffsa_pkg::ST_OK && !req_q) ? ent_start : 16'd0;
			end
			default: ;
		endcase
	end

	assign m_tvalid     = m_tvalid_q;
	assign status       = status_q;
	assign result_start = start_q;

endmodule

// ----- hdl/first_fit_segment_allocator.sv -----
// First-fit heap allocator over an address-ordered segment table in one RAM.
// Requests enter on the s_ stream: tuser is the request kind (0 allocate,
// 1 free), tdata carries owner, size and start. Each request gives exactly
// one result on the m_ stream: tdata carries status and the allocated start.
// heap_size_we with heap_size rebuilds the table as one free segment; write
// it only while no request is in flight.
// One request is handled at a time. Every table entry scanned, and every
// entry moved when a split or merge shifts the table, goes through the
// single registered RAM read port. After reset, and after a heap size write,
// the block writes the first table entry before s_tready rises. A result
// waiting on a stalled receiver holds the block in its final state; s_tready
// returns once the result is taken into the output register, so the next
// request can be accepted while that result still waits for m_tready.
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = 64,
	parameter int OWNER_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        heap_size_we,
	input  logic [15:0] heap_size,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // owner_id[7:0], alloc_size[23:8], free_start[39:24]
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[1:0], result_start[17:2], zero pad
);

	ffsa_pkg::dp_cmd_t   cmd;
	ffsa_pkg::dp_flags_t flags;
	logic [1:0]          status;
	logic [15:0]         result_start;

	ffsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.heap_size_we(heap_size_we),
		.s_tvalid    (s_tvalid),
		.flags       (flags),
		.cmd         (cmd),
		.ready       (s_tready)
	);

	ffsa_dp #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.OWNER_BITS  (OWNER_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flags       (flags),
		.heap_size_we(heap_size_we),
		.heap_size   (heap_size),
		.req_type    (s_tuser),
		.owner_id    (s_tdata[7:0]),
		.alloc_size  (s_tdata[23:8]),
		.free_start  (s_tdata[39:24]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.status      (status),
		.result_start(result_start)
	);

	assign m_tdata = {6'd0, result_start, status};

endmodule

// ----- hdl/ffsa_checker.sv -----
`include "first_fit_segment_allocator_assert.svh"

module ffsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        heap_size_we,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A stalled result must stay and keep its value.
	`FFSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Requests are handled one at a time, so the input side closes after a transfer.
	`FFSA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// A failed request or a free never reports a start.
	`FFSA_ASSERT_IMPL(a_fail_start_zero, m_tvalid && m_tdata[1:0] != 2'd0, m_tdata[17:2] == 16'd0)

	// A heap size write rebuilds the table before the next transfer is taken.
	`FFSA_ASSERT_NEXT(a_cfg_closes_input, heap_size_we, !s_tready)

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);
